// ===== rtl/ptgci_pkg.sv =====
// ----------------------------------------------------------------------------
// ptgci_pkg
// Shared constants for the two-level grid cell index block: register
// indexes, register reset values, default grid resolution limits and widths.
// ----------------------------------------------------------------------------
package ptgci_pkg;

   // Default upper limits of the coarse and fine resolution.
   localparam int MAX_COARSE_RES_DEF = 64;
   localparam int MAX_FINE_RES_DEF   = 16;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MIN_X  = 4'd0,
      REG_MIN_Y  = 4'd1,
      REG_MIN_Z  = 4'd2,
      REG_MAX_X  = 4'd3,
      REG_MAX_Y  = 4'd4,
      REG_MAX_Z  = 4'd5,
      REG_COARSE = 4'd6,
      REG_FINE   = 4'd7
   } reg_index_type;

   // Register reset values.
   localparam logic [31:0] GRID_MIN_RST   = 32'd0;
   localparam logic [31:0] GRID_MAX_RST   = 32'd65536;
   localparam logic [6:0]  COARSE_RES_RST = 7'd8;
   localparam logic [4:0]  FINE_RES_RST   = 5'd4;

   // Result field widths.
   localparam int COARSE_IDX_W = 18;
   localparam int FINE_IDX_W   = 12;

endpackage

// ===== rtl/point_to_two_level_grid_cell_index.sv =====
// ----------------------------------------------------------------------------
// point_to_two_level_grid_cell_index
// Maps a Q16.16 point into a uniform grid of coarse * fine cells per axis and
// returns the flattened coarse cell index and the flattened fine index.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     point x, y, z
// rsp_      out        rsp_tvalid/tready     valid flag, coarse and fine index
// csr_      in         csr_valid/ready       register index and value
//
// One request enters per cycle unless a stall on the result side holds it;
// QW is the quotient width of the cell divider (one bit per stage) and
// CW that of the coarse/fine split divider (one bit per stage).
// A stall on the result side freezes the whole pipeline; nothing is lost.
// Reset is synchronous, clears the valid bits and loads the configuration registers with their reset values.

module point_to_two_level_grid_cell_index #(
   parameter int MAX_COARSE_RES = ptgci_pkg::MAX_COARSE_RES_DEF,
   parameter int MAX_FINE_RES   = ptgci_pkg::MAX_FINE_RES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Fields from bit 0: point_x[31:0], point_y[63:32], point_z[95:64].
   input  logic [95:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: coarse_index[17:0], fine_index[29:18], zero fill.
   output logic [31:0] rsp_tdata,
   // Fields from bit 0: valid_res[0].
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ptgci_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ptgci_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CRW   = $clog2(MAX_COARSE_RES + 1);
   localparam int FRW   = $clog2(MAX_FINE_RES + 1);
   localparam int FULLW = CRW + FRW;
   localparam int MAXFULL = MAX_COARSE_RES * MAX_FINE_RES;
   localparam int QW    = (MAXFULL > 1) ? $clog2(MAXFULL) : 1;
   localparam int CW    = (MAX_COARSE_RES > 1) ? $clog2(MAX_COARSE_RES) : 1;
   localparam int NW    = 32 + FULLW;
   localparam int W2    = QW + FRW + CW;
   localparam int NST   = 5 + QW + CW;
   localparam int M1    = 2 + QW + CW;
   localparam int CSW   = CW + 2 * CRW + 1;
   localparam int FSW   = 3 * FRW + 1;

   // Configuration registers.
   logic signed [31:0] min_ff [3];
   logic signed [31:0] max_ff [3];
   logic [6:0]         coarse_res_ff;
   logic [4:0]         fine_res_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= ptgci_pkg::GRID_MIN_RST;
            max_ff[a] <= ptgci_pkg::GRID_MAX_RST;
         end
         coarse_res_ff <= ptgci_pkg::COARSE_RES_RST;
         fine_res_ff   <= ptgci_pkg::FINE_RES_RST;
      end else if (csr_valid) begin
         case (csr_index)
            ptgci_pkg::REG_MIN_X:  min_ff[0] <= csr_data;
            ptgci_pkg::REG_MIN_Y:  min_ff[1] <= csr_data;
            ptgci_pkg::REG_MIN_Z:  min_ff[2] <= csr_data;
            ptgci_pkg::REG_MAX_X:  max_ff[0] <= csr_data;
            ptgci_pkg::REG_MAX_Y:  max_ff[1] <= csr_data;
            ptgci_pkg::REG_MAX_Z:  max_ff[2] <= csr_data;
            ptgci_pkg::REG_COARSE: coarse_res_ff <= csr_data[6:0];
            ptgci_pkg::REG_FINE:   fine_res_ff   <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: every stage moves when the output slot is free.
   logic           advance;
   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;

   assign advance    = !v_ff[NST-1] || rsp_tready;
   assign req_tready = advance;
   assign v_in       = {v_ff[NST-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   // Input stage: clamp resolutions, form spans and offsets, check bounds.
   logic [CRW-1:0]      cr_c;
   logic [FRW-1:0]      fr_c;
   logic [FULLW-1:0]    full_c;
   logic signed [32:0]  span_c [3];
   logic signed [32:0]  off_c  [3];
   logic [2:0]          in_c;
   logic                ok_c;

   always_comb begin
      cr_c = (32'(coarse_res_ff) > MAX_COARSE_RES) ? CRW'(MAX_COARSE_RES)
                                                   : CRW'(coarse_res_ff);
      fr_c = (32'(fine_res_ff) > MAX_FINE_RES) ? FRW'(MAX_FINE_RES)
                                               : FRW'(fine_res_ff);
      full_c = FULLW'(cr_c) * FULLW'(fr_c);
      for (int a = 0; a < 3; a++) begin
         span_c[a] = $signed({max_ff[a][31], max_ff[a]})
                   - $signed({min_ff[a][31], min_ff[a]});
         off_c[a]  = $signed({req_tdata[32*a+31], req_tdata[32*a +: 32]})
                   - $signed({min_ff[a][31], min_ff[a]});
         in_c[a]   = (span_c[a] > 33'sd0) && (off_c[a] >= 33'sd0)
                   && (off_c[a] < span_c[a]);
      end
      ok_c = (&in_c) && (full_c != '0);
   end

   logic             a_ok_ff;
   logic [CRW-1:0]   a_cr_ff;
   logic [FRW-1:0]   a_fr_ff;
   logic [FULLW-1:0] a_full_ff;
   logic [31:0]      a_off_ff  [3];
   logic [31:0]      a_span_ff [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ok_ff   <= ok_c;
         a_cr_ff   <= cr_c;
         a_fr_ff   <= fr_c;
         a_full_ff <= full_c;
         for (int a = 0; a < 3; a++) begin
            a_off_ff[a]  <= off_c[a][31:0];
            a_span_ff[a] <= span_c[a][31:0];
         end
      end
   end

   // Cell divider: slot 0 holds the scaled offset, each later slot
   // resolves one quotient bit by a restoring step.
   logic [NW-1:0]  d1_rem_ff  [QW+1][3];
   logic [QW-1:0]  d1_q_ff    [QW+1][3];
   logic [31:0]    d1_span_ff [QW+1][3];
   logic           d1_ok_ff   [QW+1];
   logic [CRW-1:0] d1_cr_ff   [QW+1];
   logic [FRW-1:0] d1_fr_ff   [QW+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_ok_ff[0] <= a_ok_ff;
         d1_cr_ff[0] <= a_cr_ff;
         d1_fr_ff[0] <= a_fr_ff;
         for (int a = 0; a < 3; a++) begin
            d1_rem_ff[0][a]  <= NW'(a_off_ff[a]) * NW'(a_full_ff);
            d1_q_ff[0][a]    <= '0;
            d1_span_ff[0][a] <= a_span_ff[a];
         end
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_div1
      localparam int SH = QW - j;
      logic [NW-1:0] trial [3];
      logic [2:0]    take;
      logic [QW-1:0] q_nx  [3];

      always_comb begin
         for (int a = 0; a < 3; a++) begin
            trial[a] = NW'(d1_span_ff[j-1][a]) << SH;
            take[a]  = d1_rem_ff[j-1][a] >= trial[a];
            q_nx[a]  = d1_q_ff[j-1][a];
            q_nx[a][SH] = take[a];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            d1_ok_ff[j] <= d1_ok_ff[j-1];
            d1_cr_ff[j] <= d1_cr_ff[j-1];
            d1_fr_ff[j] <= d1_fr_ff[j-1];
            for (int a = 0; a < 3; a++) begin
               d1_span_ff[j][a] <= d1_span_ff[j-1][a];
               d1_rem_ff[j][a]  <= take[a] ? d1_rem_ff[j-1][a] - trial[a]
                                           : d1_rem_ff[j-1][a];
               d1_q_ff[j][a]    <= q_nx[a];
            end
         end
      end
   end

   // Split divider: cell / fine_res and cell % fine_res, one bit a stage.
   logic [QW-1:0]  d2_rem_ff [1:CW][3];
   logic [CW-1:0]  d2_q_ff   [1:CW][3];
   logic           d2_ok_ff  [1:CW];
   logic [CRW-1:0] d2_cr_ff  [1:CW];
   logic [FRW-1:0] d2_fr_ff  [1:CW];

   for (genvar j = 1; j <= CW; j++) begin : g_div2
      localparam int SH = CW - j;
      logic [QW-1:0]  rem_p [3];
      logic [CW-1:0]  q_p   [3];
      logic           ok_p;
      logic [CRW-1:0] cr_p;
      logic [FRW-1:0] fr_p;
      logic [W2-1:0]  trial [3];
      logic [2:0]     take;
      logic [CW-1:0]  q_nx  [3];

      // The first step takes the cell index straight from the cell divider.
      if (j == 1) begin : g_first
         assign ok_p  = d1_ok_ff[QW];
         assign cr_p  = d1_cr_ff[QW];
         assign fr_p  = d1_fr_ff[QW];
         assign rem_p = d1_q_ff[QW];
         assign q_p   = '{default: '0};
      end else begin : g_next
         assign ok_p  = d2_ok_ff[j-1];
         assign cr_p  = d2_cr_ff[j-1];
         assign fr_p  = d2_fr_ff[j-1];
         assign rem_p = d2_rem_ff[j-1];
         assign q_p   = d2_q_ff[j-1];
      end

      always_comb begin
         for (int a = 0; a < 3; a++) begin
            trial[a] = W2'(fr_p) << SH;
            take[a]  = W2'(rem_p[a]) >= trial[a];
            q_nx[a]  = q_p[a];
            q_nx[a][SH] = take[a];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            d2_ok_ff[j] <= ok_p;
            d2_cr_ff[j] <= cr_p;
            d2_fr_ff[j] <= fr_p;
            for (int a = 0; a < 3; a++) begin
               d2_rem_ff[j][a] <= take[a]
                  ? QW'(W2'(rem_p[a]) - trial[a]) : rem_p[a];
               d2_q_ff[j][a]   <= q_nx[a];
            end
         end
      end
   end

   // First flatten stage: scale the y and z parts by one resolution.
   logic             m1_ok_ff;
   logic [CRW-1:0]   m1_cr_ff;
   logic [FRW-1:0]   m1_fr_ff;
   logic [CW-1:0]    m1_gx_ff;
   logic [CW+CRW-1:0] m1_gy_ff, m1_gz_ff;
   logic [FRW-1:0]   m1_sx_ff;
   logic [2*FRW-1:0] m1_sy_ff, m1_sz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_ok_ff <= d2_ok_ff[CW];
         m1_cr_ff <= d2_cr_ff[CW];
         m1_fr_ff <= d2_fr_ff[CW];
         m1_gx_ff <= d2_q_ff[CW][0];
         m1_gy_ff <= (CW+CRW)'(d2_q_ff[CW][1]) * (CW+CRW)'(d2_cr_ff[CW]);
         m1_gz_ff <= (CW+CRW)'(d2_q_ff[CW][2]) * (CW+CRW)'(d2_cr_ff[CW]);
         m1_sx_ff <= FRW'(d2_rem_ff[CW][0]);
         m1_sy_ff <= (2*FRW)'(FRW'(d2_rem_ff[CW][1])) * (2*FRW)'(d2_fr_ff[CW]);
         m1_sz_ff <= (2*FRW)'(FRW'(d2_rem_ff[CW][2])) * (2*FRW)'(d2_fr_ff[CW]);
      end
   end

   // Second flatten stage: second scale of z and the x + y sums.
   logic           m2_ok_ff;
   logic [CSW-1:0] m2_cxy_ff, m2_cz_ff;
   logic [FSW-1:0] m2_fxy_ff, m2_fz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m2_ok_ff  <= m1_ok_ff;
         m2_cxy_ff <= CSW'(m1_gx_ff) + CSW'(m1_gy_ff);
         m2_cz_ff  <= CSW'(m1_gz_ff) * CSW'(m1_cr_ff);
         m2_fxy_ff <= FSW'(m1_sx_ff) + FSW'(m1_sy_ff);
         m2_fz_ff  <= FSW'(m1_sz_ff) * FSW'(m1_fr_ff);
      end
   end

   // Output register: final sums, masked to field widths, zero if invalid.
   logic                               out_ok_ff;
   logic [ptgci_pkg::COARSE_IDX_W-1:0] out_coarse_ff;
   logic [ptgci_pkg::FINE_IDX_W-1:0]   out_fine_ff;
   logic [CSW-1:0]                     coarse_sum;
   logic [FSW-1:0]                     fine_sum;

   assign coarse_sum = m2_cxy_ff + m2_cz_ff;
   assign fine_sum   = m2_fxy_ff + m2_fz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ok_ff     <= m2_ok_ff;
         out_coarse_ff <= m2_ok_ff ? ptgci_pkg::COARSE_IDX_W'(coarse_sum) : '0;
         out_fine_ff   <= m2_ok_ff ? ptgci_pkg::FINE_IDX_W'(fine_sum) : '0;
      end
   end

   assign rsp_tvalid = v_ff[NST-1];
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tdata  = {2'b00, out_fine_ff, out_coarse_ff};

   // Assertions.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("invalid result carries nonzero indexes");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow the output slot");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[M1] && !advance |=> v_ff[M1] && $stable(m1_gx_ff))
      else $error("pipeline stage moved during a stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
